// File: rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// Line follower PD drive package
// Shared types, constants and the speed clamp of the line follower controller.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int MaxSpeed = 16000;
  localparam bit SensorOneOnLeft = 1'b1;
  localparam int unsigned CfgAddrWidth = 5;

  typedef enum logic [2:0] {
    TsOk            = 3'd0,
    TsLostLeft      = 3'd1,
    TsLostRight     = 3'd2,
    TsDiscontinuous = 3'd3,
    TsLostUnknown   = 3'd4,
    TsUnknown       = 3'd5,
    TsNoData        = 3'd6
  } track_state_e;

  typedef enum logic [2:0] {
    RegBaseSpeed       = 3'd0,
    RegTurnSlowdown    = 3'd1,
    RegKpGain          = 3'd2,
    RegKdGain          = 3'd3,
    RegMinForwardSpeed = 3'd4,
    RegLostInnerSpeed  = 3'd5,
    RegLostOuterSpeed  = 3'd6,
    RegSlewStep        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    track_state_e       track_state;
    logic signed [11:0] line_position;
    logic [7:0]         tick_count;
  } lfpd_in_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } lfpd_out_t;

  typedef struct packed {
    logic signed [15:0] cruise_speed;
    logic [15:0]        turn_slowdown;
    logic [15:0]        kp_gain;
    logic [15:0]        kd_gain;
    logic signed [15:0] min_forward_speed;
    logic signed [15:0] lost_inner_speed;
    logic signed [15:0] lost_outer_speed;
    logic [14:0]        slew_step;
  } lfpd_cfg_t;

  function automatic logic signed [15:0] clamp_speed(input logic signed [23:0] value);
    logic signed [23:0] limit;
    limit = 24'(MaxSpeed);
    if (value > limit) begin
      return 16'(limit);
    end else if (value < -limit) begin
      return 16'(-limit);
    end else begin
      return value[15:0];
    end
  endfunction

endpackage

// File: rtl/lfpd_steer.sv
// ----------------------------------------------------------------------------
// Line follower PD steering
// Computes the PD wheel targets for one position error against the last one.
// ----------------------------------------------------------------------------
module lfpd_steer (
  input  lfpd_pkg::lfpd_cfg_t cfg_i,
  input  logic signed [11:0]  err_i,
  input  logic signed [11:0]  prev_err_i,
  output logic signed [15:0]  left_o,
  output logic signed [15:0]  right_o
);

  logic [11:0]        mag;
  logic [27:0]        slow_prod;
  logic signed [21:0] base_raw;
  logic signed [21:0] min_fwd;
  logic signed [21:0] base;
  logic signed [12:0] diff;
  logic signed [28:0] p_prod;
  logic signed [29:0] d_prod;
  logic signed [29:0] corr_sum;
  logic signed [21:0] corr;
  logic signed [23:0] left_sum;
  logic signed [23:0] right_sum;
  logic signed [15:0] left_clamped;
  logic signed [15:0] right_clamped;

  assign mag       = err_i[11] ? 12'(-err_i) : 12'(err_i);
  assign slow_prod = mag * cfg_i.turn_slowdown;
  assign base_raw  = 22'(cfg_i.cruise_speed) - $signed({2'b00, slow_prod[27:8]});
  assign min_fwd   = 22'(cfg_i.min_forward_speed);
  assign base      = (base_raw < min_fwd) ? min_fwd : base_raw;

  assign diff      = 13'(err_i) - 13'(prev_err_i);
  assign p_prod    = $signed({1'b0, cfg_i.kp_gain}) * err_i;
  assign d_prod    = $signed({1'b0, cfg_i.kd_gain}) * diff;
  assign corr_sum  = 30'(p_prod) + d_prod;
  assign corr      = $signed(corr_sum[29:8]);

  assign left_sum  = 24'(base) + 24'(corr);
  assign right_sum = 24'(base) - 24'(corr);

  assign left_clamped  = lfpd_pkg::clamp_speed(left_sum);
  assign right_clamped = lfpd_pkg::clamp_speed(right_sum);

  assign left_o  = (left_clamped < cfg_i.min_forward_speed) ?
                   cfg_i.min_forward_speed : left_clamped;
  assign right_o = (right_clamped < cfg_i.min_forward_speed) ?
                   cfg_i.min_forward_speed : right_clamped;

endmodule

// File: rtl/line_follow_pd_differential_drive.sv
// ----------------------------------------------------------------------------
// Line follower PD differential drive
// Turns one line-sensor word into a slew-limited pair of wheel speed targets.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_ready_o    track state, position, ticks
// out      output     out_valid_o / out_ready_i  left and right speed
// cfg      input      APB psel/penable/pready    eight control registers
//
// A word is registered in the input register on acceptance; its result is
// registered into the held speeds once the output slot is free and offered
// from there; a new word can be taken every cycle unless the output stalls.
// The held speeds and the last error feed back through one register stage.
// Reset clears the control registers, the held speeds, the last error and
// both valid flags to zero.
// A stalled output holds its word; one further input word waits in the
// input register meanwhile.
// ----------------------------------------------------------------------------
module line_follow_pd_differential_drive (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lfpd_pkg::lfpd_in_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lfpd_pkg::lfpd_out_t                 out_word_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfpd_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  lfpd_pkg::lfpd_cfg_t cfg_q;
  lfpd_pkg::lfpd_in_t  in_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic signed [15:0]  held_left_q;
  logic signed [15:0]  held_right_q;
  logic signed [15:0]  held_left_d;
  logic signed [15:0]  held_right_d;
  logic signed [11:0]  prev_err_q;

  lfpd_pkg::cfg_reg_e  reg_sel;
  logic                cfg_write;
  logic                advance;
  logic signed [11:0]  pos;
  logic signed [11:0]  err_sel;
  logic                use_pd;
  logic signed [15:0]  pd_left;
  logic signed [15:0]  pd_right;
  logic signed [15:0]  tgt_left;
  logic signed [15:0]  tgt_right;
  logic signed [15:0]  lim_left;
  logic signed [15:0]  lim_right;
  logic [22:0]         step;
  logic signed [24:0]  step_s;
  logic signed [24:0]  left_hi;
  logic signed [24:0]  left_lo;
  logic signed [24:0]  right_hi;
  logic signed [24:0]  right_lo;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_sel   = lfpd_pkg::cfg_reg_e'(paddr[lfpd_pkg::CfgAddrWidth-1:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        lfpd_pkg::RegBaseSpeed:       cfg_q.cruise_speed      <= pwdata[15:0];
        lfpd_pkg::RegTurnSlowdown:    cfg_q.turn_slowdown     <= pwdata[15:0];
        lfpd_pkg::RegKpGain:          cfg_q.kp_gain           <= pwdata[15:0];
        lfpd_pkg::RegKdGain:          cfg_q.kd_gain           <= pwdata[15:0];
        lfpd_pkg::RegMinForwardSpeed: cfg_q.min_forward_speed <= pwdata[15:0];
        lfpd_pkg::RegLostInnerSpeed:  cfg_q.lost_inner_speed  <= pwdata[15:0];
        lfpd_pkg::RegLostOuterSpeed:  cfg_q.lost_outer_speed  <= pwdata[15:0];
        lfpd_pkg::RegSlewStep:        cfg_q.slew_step         <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lfpd_pkg::RegBaseSpeed:       prdata = 32'(cfg_q.cruise_speed);
      lfpd_pkg::RegTurnSlowdown:    prdata = 32'(cfg_q.turn_slowdown);
      lfpd_pkg::RegKpGain:          prdata = 32'(cfg_q.kp_gain);
      lfpd_pkg::RegKdGain:          prdata = 32'(cfg_q.kd_gain);
      lfpd_pkg::RegMinForwardSpeed: prdata = 32'(cfg_q.min_forward_speed);
      lfpd_pkg::RegLostInnerSpeed:  prdata = 32'(cfg_q.lost_inner_speed);
      lfpd_pkg::RegLostOuterSpeed:  prdata = 32'(cfg_q.lost_outer_speed);
      lfpd_pkg::RegSlewStep:        prdata = 32'(cfg_q.slew_step);
      default:                      prdata = '0;
    endcase
  end

  // Handshake: the result stage moves whenever the input register holds a word and the output slot is free.
  assign advance     = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~in_valid_q | advance;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = '{left_speed: held_left_q, right_speed: held_right_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  // Target selection.
  always_comb begin
    if (lfpd_pkg::SensorOneOnLeft) begin
      pos = in_q.line_position;
    end else if (in_q.line_position == -12'sd2048) begin
      pos = 12'sd2047;
    end else begin
      pos = 12'(-in_q.line_position);
    end
  end

  always_comb begin
    err_sel   = prev_err_q;
    use_pd    = 1'b0;
    tgt_left  = cfg_q.cruise_speed;
    tgt_right = cfg_q.cruise_speed;
    case (in_q.track_state)
      lfpd_pkg::TsOk: begin
        err_sel   = pos;
        use_pd    = 1'b1;
        tgt_left  = pd_left;
        tgt_right = pd_right;
      end
      lfpd_pkg::TsLostLeft: begin
        tgt_left  = cfg_q.lost_inner_speed;
        tgt_right = cfg_q.lost_outer_speed;
      end
      lfpd_pkg::TsLostRight: begin
        tgt_left  = cfg_q.lost_outer_speed;
        tgt_right = cfg_q.lost_inner_speed;
      end
      lfpd_pkg::TsDiscontinuous, lfpd_pkg::TsLostUnknown, lfpd_pkg::TsUnknown: begin
        use_pd    = 1'b1;
        tgt_left  = pd_left;
        tgt_right = pd_right;
      end
      default: ;
    endcase
  end

  lfpd_steer u_steer (
    .cfg_i      (cfg_q),
    .err_i      (err_sel),
    .prev_err_i (prev_err_q),
    .left_o     (pd_left),
    .right_o    (pd_right)
  );

  assign lim_left  = lfpd_pkg::clamp_speed(24'(tgt_left));
  assign lim_right = lfpd_pkg::clamp_speed(24'(tgt_right));

  // Slew limit around the held speeds.
  assign step     = cfg_q.slew_step * in_q.tick_count;
  assign step_s   = $signed({2'b00, step});
  assign left_hi  = 25'(held_left_q) + step_s;
  assign left_lo  = 25'(held_left_q) - step_s;
  assign right_hi = 25'(held_right_q) + step_s;
  assign right_lo = 25'(held_right_q) - step_s;

  always_comb begin
    if (25'(lim_left) > left_hi) begin
      held_left_d = left_hi[15:0];
    end else if (25'(lim_left) < left_lo) begin
      held_left_d = left_lo[15:0];
    end else begin
      held_left_d = lim_left;
    end
    if (25'(lim_right) > right_hi) begin
      held_right_d = right_hi[15:0];
    end else if (25'(lim_right) < right_lo) begin
      held_right_d = right_lo[15:0];
    end else begin
      held_right_d = lim_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_left_q  <= '0;
      held_right_q <= '0;
      prev_err_q   <= '0;
    end else if (advance && (in_q.tick_count != 8'd0)) begin
      held_left_q  <= held_left_d;
      held_right_q <= held_right_d;
      if (use_pd) begin
        prev_err_q <= err_sel;
      end
    end
  end

endmodule

// File: dv/lfpd_speed_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line follower speed checker
// Watches the input, output and register ports of the line follower, works out
// every speed word from its own copy of the registers and the held state, and
// compares each output word with the oldest one still waiting.
// ----------------------------------------------------------------------------
module lfpd_speed_checker
  import lfpd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  lfpd_in_t                in_word_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  lfpd_out_t               out_word_i,
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic                    pready_i,
  input  logic [CfgAddrWidth-1:0] paddr_i,
  input  logic [31:0]             pwdata_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  lfpd_cfg_t          regs;
  logic signed [15:0] held_left;
  logic signed [15:0] held_right;
  logic signed [11:0] last_error;
  lfpd_out_t          expected_speeds[$];
  int unsigned        mismatch_count;
  int unsigned        word_count;

  function automatic longint limit_speed(longint v);
    if (v > MaxSpeed) return MaxSpeed;
    if (v < -MaxSpeed) return -MaxSpeed;
    return v;
  endfunction

  function automatic longint approach(longint cur, longint tgt, longint step);
    if (tgt > cur + step) return cur + step;
    if (tgt < cur - step) return cur - step;
    return tgt;
  endfunction

  task automatic steer_pd(input longint err, output longint left, output longint right);
    longint mag;
    longint base;
    longint corr;
    longint floor_speed;
    floor_speed = longint'($signed(regs.min_forward_speed));
    mag = (err < 0) ? -err : err;
    base = longint'($signed(regs.cruise_speed)) - ((mag * longint'(regs.turn_slowdown)) >>> 8);
    corr = (longint'(regs.kp_gain) * err
            + longint'(regs.kd_gain) * (err - longint'(last_error))) >>> 8;
    if (base < floor_speed) base = floor_speed;
    left = limit_speed(base + corr);
    right = limit_speed(base - corr);
    if (left < floor_speed) left = floor_speed;
    if (right < floor_speed) right = floor_speed;
    last_error = 12'(err);
  endtask

  task automatic predict_wheel_speeds(input lfpd_in_t w);
    longint    pos;
    longint    tgt_left;
    longint    tgt_right;
    longint    step;
    lfpd_out_t speeds;
    pos = longint'($signed(w.line_position));
    tgt_left = longint'($signed(regs.cruise_speed));
    tgt_right = tgt_left;
    if (w.tick_count != 8'd0) begin
      case (w.track_state)
        TsOk: begin
          if (!SensorOneOnLeft) begin
            pos = -pos;
            if (pos > 2047) pos = 2047;
          end
          steer_pd(pos, tgt_left, tgt_right);
        end
        TsLostLeft: begin
          tgt_left = longint'($signed(regs.lost_inner_speed));
          tgt_right = longint'($signed(regs.lost_outer_speed));
        end
        TsLostRight: begin
          tgt_left = longint'($signed(regs.lost_outer_speed));
          tgt_right = longint'($signed(regs.lost_inner_speed));
        end
        TsDiscontinuous, TsLostUnknown, TsUnknown: begin
          steer_pd(longint'(last_error), tgt_left, tgt_right);
        end
        default: begin
        end
      endcase
      step = longint'(regs.slew_step) * longint'(w.tick_count);
      held_left = 16'(approach(longint'(held_left), limit_speed(tgt_left), step));
      held_right = 16'(approach(longint'(held_right), limit_speed(tgt_right), step));
    end
    speeds.left_speed = held_left;
    speeds.right_speed = held_right;
    expected_speeds.push_back(speeds);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] data);
    case (cfg_reg_e'(index))
      RegBaseSpeed:       regs.cruise_speed = data[15:0];
      RegTurnSlowdown:    regs.turn_slowdown = data[15:0];
      RegKpGain:          regs.kp_gain = data[15:0];
      RegKdGain:          regs.kd_gain = data[15:0];
      RegMinForwardSpeed: regs.min_forward_speed = data[15:0];
      RegLostInnerSpeed:  regs.lost_inner_speed = data[15:0];
      RegLostOuterSpeed:  regs.lost_outer_speed = data[15:0];
      RegSlewStep:        regs.slew_step = data[14:0];
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_ports
    lfpd_out_t want;
    if (!rst_ni) begin
      regs = '0;
      held_left = '0;
      held_right = '0;
      last_error = '0;
      expected_speeds.delete();
      mismatch_count = 0;
      word_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        write_register(paddr_i[CfgAddrWidth-1:2], pwdata_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_speeds.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("speed word %0d arrived unasked: left %0d, right %0d", word_count,
                     $signed(out_word_i.left_speed), $signed(out_word_i.right_speed));
          end
          mismatch_count++;
        end else begin
          want = expected_speeds.pop_front();
          if (want.left_speed !== out_word_i.left_speed ||
              want.right_speed !== out_word_i.right_speed) begin
            if (mismatch_count < 10) begin
              $display("speed word %0d: left expected %0d, got %0d; right expected %0d, got %0d",
                       word_count, $signed(want.left_speed), $signed(out_word_i.left_speed),
                       $signed(want.right_speed), $signed(out_word_i.right_speed));
            end
            mismatch_count++;
          end
        end
        word_count++;
      end
      if (in_valid_i && in_ready_i) begin
        predict_wheel_speeds(in_word_i);
      end
      fail_count_o <= mismatch_count;
      pending_o <= expected_speeds.size();
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line follower PD drive testbench
// Feeds sensor words through the line follower under several register
// settings, extremes among them, with random gaps on both channels, and leaves
// all checking of speed words to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  import lfpd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned WordsPerPhase = 146;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  lfpd_in_t                in_word_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  lfpd_out_t               out_word_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  int unsigned             fail_count;
  int unsigned             pending;
  int unsigned             cycle_count = 0;
  bit                      steady = 1'b0;

  line_follow_pd_differential_drive i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  lfpd_speed_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic lfpd_in_t make_word(track_state_e st, logic signed [11:0] pos,
                                         logic [7:0] ticks);
    lfpd_in_t w;
    w.track_state = st;
    w.line_position = pos;
    w.tick_count = ticks;
    return w;
  endfunction

  function automatic lfpd_in_t random_word();
    lfpd_in_t     w;
    int unsigned  r;
    track_state_e st;
    r = $urandom_range(0, 99);
    if (r < 55) st = TsOk;
    else if (r < 65) st = TsLostLeft;
    else if (r < 75) st = TsLostRight;
    else if (r < 80) st = TsDiscontinuous;
    else if (r < 85) st = TsLostUnknown;
    else if (r < 90) st = TsUnknown;
    else st = TsNoData;
    w.track_state = st;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0: w.line_position = 12'h800;
        1: w.line_position = 12'h7FF;
        2: w.line_position = 12'h000;
        default: w.line_position = 12'hFFF;
      endcase
    end else if (r < 60) begin
      w.line_position = 12'($urandom_range(0, 1023)) - 12'd512;
    end else begin
      w.line_position = 12'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 8) w.tick_count = 8'd0;
    else if (r < 80) w.tick_count = 8'($urandom_range(1, 4));
    else w.tick_count = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic lfpd_cfg_t phase_settings(int unsigned phase);
    lfpd_cfg_t s;
    case (phase)
      0: begin
        s.cruise_speed = 16'sh7FFF;
        s.turn_slowdown = 16'hFFFF;
        s.kp_gain = 16'hFFFF;
        s.kd_gain = 16'hFFFF;
        s.min_forward_speed = 16'sh7FFF;
        s.lost_inner_speed = 16'sh8000;
        s.lost_outer_speed = 16'sh7FFF;
        s.slew_step = 15'h7FFF;
      end
      1: begin
        s.cruise_speed = 16'sh8000;
        s.turn_slowdown = 16'h0000;
        s.kp_gain = 16'h0000;
        s.kd_gain = 16'h0000;
        s.min_forward_speed = 16'sh8000;
        s.lost_inner_speed = 16'sh7FFF;
        s.lost_outer_speed = 16'sh8000;
        s.slew_step = 15'h0000;
      end
      2: begin
        s.cruise_speed = 16'sd6000;
        s.turn_slowdown = 16'hFFFF;
        s.kp_gain = 16'hFFFF;
        s.kd_gain = 16'hFFFF;
        s.min_forward_speed = 16'sh8000;
        s.lost_inner_speed = 16'sh8000;
        s.lost_outer_speed = 16'sh7FFF;
        s.slew_step = 15'h7FFF;
      end
      default: begin
        s.cruise_speed = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 8000));
        s.turn_slowdown = 16'($urandom_range(0, 2000));
        s.kp_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000));
        s.kd_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000));
        s.min_forward_speed = 16'($urandom_range(0, 4000)) - 16'd2000;
        s.lost_inner_speed = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 12000)) - 16'd4000;
        s.lost_outer_speed = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 16000));
        s.slew_step = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                  : 15'($urandom_range(50, 3000));
      end
    endcase
    return s;
  endfunction

  task automatic write_register(input cfg_reg_e index, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrWidth'({index, 2'b00});
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input lfpd_cfg_t s);
    write_register(RegBaseSpeed, {16'h0, s.cruise_speed});
    write_register(RegTurnSlowdown, {16'h0, s.turn_slowdown});
    write_register(RegKpGain, {16'h0, s.kp_gain});
    write_register(RegKdGain, {16'h0, s.kd_gain});
    write_register(RegMinForwardSpeed, {16'h0, s.min_forward_speed});
    write_register(RegLostInnerSpeed, {16'h0, s.lost_inner_speed});
    write_register(RegLostOuterSpeed, {16'h0, s.lost_outer_speed});
    write_register(RegSlewStep, {17'h0, s.slew_step});
  endtask

  task automatic send_word(input lfpd_in_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    lfpd_cfg_t s;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at reset: every word keeps both wheels at zero.
    send_word(make_word(TsOk, 12'h7FF, 8'd1));
    send_word(make_word(TsLostLeft, 12'h000, 8'd255));
    drain();

    s.cruise_speed = 16'sd4000;
    s.turn_slowdown = 16'd300;
    s.kp_gain = 16'd2000;
    s.kd_gain = 16'd800;
    s.min_forward_speed = 16'sd500;
    s.lost_inner_speed = -16'sd1000;
    s.lost_outer_speed = 16'sd6000;
    s.slew_step = 15'd3000;
    load_settings(s);
    send_word(make_word(TsOk, 12'h000, 8'd1));
    send_word(make_word(TsOk, 12'h7FF, 8'd1));
    send_word(make_word(TsOk, 12'h800, 8'd1));
    send_word(make_word(TsOk, 12'hFFF, 8'd255));
    send_word(make_word(TsDiscontinuous, 12'h000, 8'd1));
    send_word(make_word(TsOk, 12'h600, 8'd2));
    send_word(make_word(TsLostUnknown, 12'h155, 8'd2));
    send_word(make_word(TsUnknown, 12'h2AA, 8'd1));
    send_word(make_word(TsOk, 12'h200, 8'd0));
    send_word(make_word(TsLostLeft, 12'h000, 8'd3));
    send_word(make_word(TsLostRight, 12'h000, 8'd3));
    send_word(make_word(TsNoData, 12'h7FF, 8'd1));
    send_word(make_word(TsOk, 12'h7FF, 8'd255));
    send_word(make_word(TsUnknown, 12'h000, 8'd255));
    send_word(make_word(TsOk, 12'h800, 8'd255));
    send_word(make_word(TsLostLeft, 12'h800, 8'd255));
    send_word(make_word(TsNoData, 12'h000, 8'd0));
    send_word(make_word(TsLostRight, 12'h7FF, 8'd128));
    send_word(make_word(TsOk, 12'h080, 8'd1));
    send_word(make_word(TsNoData, 12'h000, 8'd255));
    drain();

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      load_settings(phase_settings(phase));
      steady = (phase == 3);
      for (int unsigned n = 0; n < WordsPerPhase; n++) begin
        // Halfway through, hold the sender back until the block is empty.
        if (n == WordsPerPhase / 2) drain();
        send_word(random_word());
      end
      drain();
    end
    steady = 1'b0;

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
